### src/lef_pkg.sv
// Shared types and constants for the 3x3 Laplacian edge filter.
`timescale 1ns / 1ps
`default_nettype none

package lef_pkg;

    // Frame geometry
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int MIN_SIZE      = 3;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;
    localparam int ROW_W         = 10;

    // Pixel and channel widths
    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Input word opcodes
    localparam logic OPC_PIXEL = 1'b0;
    localparam logic OPC_DRAIN = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1
    } t_cfg_reg;

    // Work classes handed from the front to the back
    typedef enum logic [2:0] {
        OP_SILENT      = 3'd0,  // pixel that shifts the window, no result
        OP_BORDER      = 3'd1,  // pixel whose result is the unfiltered center
        OP_FILTER      = 3'd2,  // pixel whose result is the Laplacian
        OP_EDGE        = 3'd3,  // pixel whose result is the last pixel of the upper row
        OP_DRAIN_UPPER = 3'd4,  // drain word, result from the upper row end
        OP_DRAIN_LOWER = 3'd5   // drain word, result from the lower line store
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [PIX_W-1:0]  pix;
        logic              frame_end;
        logic              last_col;
    } t_cmd;

endpackage

`default_nettype wire

### src/lef_stream_if.sv
// Handshake channels for pixel words in and result words out.
`timescale 1ns / 1ps
`default_nettype none

interface lef_pix_if;
    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic [lef_pkg::CH_W-1:0] red_in;
    logic [lef_pkg::CH_W-1:0] green_in;
    logic [lef_pkg::CH_W-1:0] blue_in;

    modport source (output valid, opcode, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, opcode, red_in, green_in, blue_in, output ready);
endinterface

interface lef_res_if;
    logic                    valid;
    logic                    ready;
    logic [lef_pkg::CH_W-1:0] red_out;
    logic [lef_pkg::CH_W-1:0] green_out;
    logic [lef_pkg::CH_W-1:0] blue_out;
    logic                    frame_end;

    modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

`default_nettype wire

### src/lef_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lef_ram #(
    parameter int WIDTH = lef_pkg::PIX_W,
    parameter int DEPTH = lef_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds without a read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/lef_fifo.sv
// Short register queue carrying commands from the front to the back.
`timescale 1ns / 1ps
`default_nettype none

module lef_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lef_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;

    // Advance pointers with explicit wrap
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count past depth");

endmodule

`default_nettype wire

### src/lef_front.sv
// Front end: accepts words, tracks frame position and owed results, classifies work.
`timescale 1ns / 1ps
`default_nettype none

module lef_front #(
    parameter int MAX_WIDTH = lef_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    lef_pix_if.sink                               i_pix,
    input  wire logic                             i_cfg_we,
    input  wire logic [lef_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [lef_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_full,
    output logic                                  o_push,
    output lef_pkg::t_cmd                         o_cmd,
    output logic      [$clog2(MAX_WIDTH)-1:0]     o_col
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 2);
    localparam int DW = lef_pkg::CFG_DATA_W;

    localparam logic [lef_pkg::ROW_W-1:0] ROW_ONE = lef_pkg::ROW_W'(1);

    function automatic logic [WW-1:0] clamp_w(input logic [DW-1:0] v);
        logic [31:0] x;
        x = 32'(v);
        if (x < 32'(lef_pkg::MIN_SIZE)) x = 32'(lef_pkg::MIN_SIZE);
        if (x > 32'(MAX_WIDTH)) x = 32'(MAX_WIDTH);
        return WW'(x);
    endfunction

    function automatic logic [DW-1:0] clamp_h(input logic [DW-1:0] v);
        logic [31:0] x;
        x = 32'(v);
        if (x < 32'(lef_pkg::MIN_SIZE)) x = 32'(lef_pkg::MIN_SIZE);
        if (x > 32'(lef_pkg::MAX_HEIGHT)) x = 32'(lef_pkg::MAX_HEIGHT);
        return DW'(x);
    endfunction

    logic [WW-1:0]               r_w, n_w;
    logic [DW-1:0]               r_h, n_h;
    logic [lef_pkg::ROW_W-1:0]   r_row, n_row;
    logic [AW-1:0]               r_col, n_col;
    logic [WW-1:0]               r_pending, n_pending;

    logic          accept;
    logic [WW-1:0] full_cnt;
    logic [WW-1:0] pend_base;
    logic          at_start;
    logic          col_last;
    logic          row_last;
    logic          emit;

    assign i_pix.ready = !i_full;
    assign accept      = i_pix.valid && i_pix.ready;
    assign full_cnt    = r_w + 1'b1;
    assign at_start    = (r_row == '0) && (r_col == '0);
    assign col_last    = (WW'(r_col) == r_w - 1'b1);
    assign row_last    = (DW'(r_row) == r_h - 1'b1);

    // Classify each word and step the frame position
    always_comb begin
        n_w           = r_w;
        n_h           = r_h;
        n_row         = r_row;
        n_col         = r_col;
        n_pending     = r_pending;
        pend_base     = r_pending;
        emit          = 1'b0;
        o_push        = 1'b0;
        o_col         = r_col;
        o_cmd.op        = lef_pkg::OP_SILENT;
        o_cmd.pix       = {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
        o_cmd.frame_end = 1'b0;
        o_cmd.last_col  = col_last;

        if (i_cfg_we) begin
            // A size write restarts the frame
            unique case (i_cfg_index)
                lef_pkg::REG_WIDTH: begin
                    n_w       = clamp_w(i_cfg_data);
                    n_row     = '0;
                    n_col     = '0;
                    n_pending = '0;
                end
                lef_pkg::REG_HEIGHT: begin
                    n_h       = clamp_h(i_cfg_data);
                    n_row     = '0;
                    n_col     = '0;
                    n_pending = '0;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            if (i_pix.opcode == lef_pkg::OPC_DRAIN) begin
                // Drain only at frame start with results owed; otherwise drop
                if (at_start && (r_pending != '0)) begin
                    o_push          = 1'b1;
                    o_cmd.op        = (r_pending == full_cnt) ? lef_pkg::OP_DRAIN_UPPER
                                                              : lef_pkg::OP_DRAIN_LOWER;
                    o_cmd.frame_end = (r_pending == WW'(1));
                    o_cmd.last_col  = 1'b0;
                    o_col           = AW'(r_w - r_pending);
                    n_pending       = r_pending - 1'b1;
                end
            end else begin
                // Abandon a partial drain when a new frame starts
                if (at_start && (r_pending != full_cnt)) begin
                    pend_base = '0;
                end
                emit      = (pend_base == full_cnt);
                n_pending = emit ? pend_base : pend_base + 1'b1;
                o_push    = 1'b1;
                if (!emit) begin
                    o_cmd.op = lef_pkg::OP_SILENT;
                end else if (r_col == '0) begin
                    o_cmd.op = lef_pkg::OP_EDGE;
                end else if ((r_row == '0) || (r_row == ROW_ONE) || (r_col == AW'(1))) begin
                    o_cmd.op = lef_pkg::OP_BORDER;
                end else begin
                    o_cmd.op = lef_pkg::OP_FILTER;
                end
                o_cmd.frame_end = emit && (r_col == '0) && (r_row == ROW_ONE);
                if (col_last) begin
                    n_col = '0;
                    n_row = row_last ? '0 : r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= clamp_w(DW'(lef_pkg::WIDTH_RESET));
            r_h       <= clamp_h(DW'(lef_pkg::HEIGHT_RESET));
            r_row     <= '0;
            r_col     <= '0;
            r_pending <= '0;
        end else begin
            r_w       <= n_w;
            r_h       <= n_h;
            r_row     <= n_row;
            r_col     <= n_col;
            r_pending <= n_pending;
        end
    end

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= full_cnt)
        else $error("owed results exceed one row plus one");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_col) < r_w)
        else $error("column position past frame width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        DW'(r_row) < r_h)
        else $error("row position past frame height");

endmodule

`default_nettype wire

### src/lef_back.sv
// Back end: line stores, 3x3 window, Laplacian and the output register.
`timescale 1ns / 1ps
`default_nettype none

module lef_back #(
    parameter int MAX_WIDTH = lef_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_empty,
    input  wire lef_pkg::t_cmd                i_cmd,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] i_col,
    output logic                              o_pop,
    lef_res_if.source                         o_res
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PW = lef_pkg::PIX_W;
    localparam int CW = lef_pkg::CH_W;

    // Per-channel 4*center minus the four neighbors, clamped to 0..255
    function automatic logic [CW-1:0] lap(input logic [CW-1:0] c, input logic [CW-1:0] n,
                                          input logic [CW-1:0] s, input logic [CW-1:0] e,
                                          input logic [CW-1:0] w);
        logic signed [CW+3:0] v;
        v = $signed({2'b00, c, 2'b00}) - $signed({4'b0000, n}) - $signed({4'b0000, s})
          - $signed({4'b0000, e}) - $signed({4'b0000, w});
        if (v < 0) return '0;
        if (v > $signed((CW+4)'({CW{1'b1}}))) return {CW{1'b1}};
        return v[CW-1:0];
    endfunction

    // Execute stage
    logic              r_x_valid;
    lef_pkg::t_op      r_x_op;
    logic [PW-1:0]     r_x_pix;
    logic              r_x_fe;
    logic              r_x_last;
    logic [AW-1:0]     r_x_col;

    // Window taps that reach the filter, and the upper row's last pixel
    logic [PW-1:0]     r_w2, r_w4, r_w5, r_w8;
    logic [PW-1:0]     r_edge;

    // Output register
    logic              r_o_valid;
    logic [PW-1:0]     r_o_pix;
    logic              r_o_fe;

    logic [PW-1:0]     up_rdata;
    logic [PW-1:0]     lo_rdata;
    logic [PW-1:0]     lap_pix;
    logic [PW-1:0]     x_val;
    logic              x_emit;
    logic              x_pixel;
    logic              x_fire;
    logic              x_adv;
    logic              out_free;
    logic              mem_we;

    assign x_emit   = (r_x_op != lef_pkg::OP_SILENT);
    assign x_pixel  = (r_x_op != lef_pkg::OP_DRAIN_UPPER) && (r_x_op != lef_pkg::OP_DRAIN_LOWER);
    assign out_free = !r_o_valid || o_res.ready;
    assign x_fire   = r_x_valid && (!x_emit || out_free);
    assign x_adv    = !r_x_valid || x_fire;
    assign o_pop    = !i_empty && x_adv;
    assign mem_we   = x_fire && x_pixel;

    // Upper store takes the row leaving the lower store
    lef_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_x_col),
        .i_wdata (lo_rdata),
        .i_re    (o_pop),
        .i_raddr (i_col),
        .o_rdata (up_rdata)
    );

    // Lower store takes the incoming pixel
    lef_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_lower (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_x_col),
        .i_wdata (r_x_pix),
        .i_re    (o_pop),
        .i_raddr (i_col),
        .o_rdata (lo_rdata)
    );

    // Filter on the shifted window: center is r_w5, west is the lower store read
    assign lap_pix = {
        lap(r_w5[3*CW-1:2*CW], r_w2[3*CW-1:2*CW], r_w8[3*CW-1:2*CW],
            r_w4[3*CW-1:2*CW], lo_rdata[3*CW-1:2*CW]),
        lap(r_w5[2*CW-1:CW], r_w2[2*CW-1:CW], r_w8[2*CW-1:CW],
            r_w4[2*CW-1:CW], lo_rdata[2*CW-1:CW]),
        lap(r_w5[CW-1:0], r_w2[CW-1:0], r_w8[CW-1:0],
            r_w4[CW-1:0], lo_rdata[CW-1:0])
    };

    // Select the result word
    always_comb begin
        unique case (r_x_op) inside
            lef_pkg::OP_EDGE, lef_pkg::OP_DRAIN_UPPER: x_val = r_edge;
            lef_pkg::OP_FILTER:                        x_val = lap_pix;
            lef_pkg::OP_DRAIN_LOWER:                   x_val = lo_rdata;
            default:                                   x_val = r_w5;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_w2      <= '0;
            r_w4      <= '0;
            r_w5      <= '0;
            r_w8      <= '0;
        end else begin
            // Load the next command; its store reads land next cycle
            if (o_pop) begin
                r_x_valid <= 1'b1;
            end else if (x_fire) begin
                r_x_valid <= 1'b0;
            end
            // Shift the window
            if (mem_we) begin
                r_w2 <= up_rdata;
                r_w4 <= r_w5;
                r_w5 <= lo_rdata;
                r_w8 <= r_x_pix;
            end
            // Hold the result until taken
            if (x_fire && x_emit) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_x_op   <= i_cmd.op;
            r_x_pix  <= i_cmd.pix;
            r_x_fe   <= i_cmd.frame_end;
            r_x_last <= i_cmd.last_col;
            r_x_col  <= i_col;
        end
        // Mirror the upper store entry at the last column
        if (mem_we && r_x_last) begin
            r_edge <= lo_rdata;
        end
        if (x_fire && x_emit) begin
            r_o_pix <= x_val;
            r_o_fe  <= r_x_fe;
        end
    end

    assign o_res.valid     = r_o_valid;
    assign o_res.red_out   = r_o_pix[3*CW-1:2*CW];
    assign o_res.green_out = r_o_pix[2*CW-1:CW];
    assign o_res.blue_out  = r_o_pix[CW-1:0];
    assign o_res.frame_end = r_o_fe;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_x_valid && !x_fire) |=> (r_x_valid && $stable(r_x_col) && $stable(r_x_op)))
        else $error("stalled command changed in execute stage");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (x_fire && x_emit) |-> out_free)
        else $error("result loaded over an untaken word");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_res.ready) |=> (r_o_valid && $stable(r_o_pix) && $stable(r_o_fe)))
        else $error("result word changed before it was taken");

endmodule

`default_nettype wire

### src/laplacian_edge_filter_3x3_top.sv
// Top level of the 3x3 Laplacian edge filter: front, command queue and back.
// Path: a releasing word goes through the queue, the execute stage and the output register;
//   results trail the pixel stream by W+1 words (one row plus one pixel).
// Throughput: one word per clock while o_res is ready; set by each store's single read port.
// Reset: clears position, owed count, window and handshakes; size returns to 640x480.
//   Line stores are not cleared; no result depends on an entry before it is written.
`timescale 1ns / 1ps
`default_nettype none

module laplacian_edge_filter_3x3_top #(
    parameter int MAX_WIDTH = lef_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    lef_pix_if.sink                             i_pix,
    lef_res_if.source                           o_res,
    input  wire logic                           i_cfg_we,
    input  wire logic [lef_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lef_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int QW = $bits(lef_pkg::t_cmd) + AW;

    logic              push;
    lef_pkg::t_cmd     push_cmd;
    logic [AW-1:0]     push_col;
    logic              q_full;
    logic              q_empty;
    logic              pop;
    logic [QW-1:0]     q_data;
    lef_pkg::t_cmd     pop_cmd;
    logic [AW-1:0]     pop_col;

    lef_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_full      (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .o_col       (push_col)
    );

    lef_fifo #(.WIDTH(QW), .DEPTH(lef_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_cmd, push_col}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    assign pop_cmd = lef_pkg::t_cmd'(q_data[QW-1:AW]);
    assign pop_col = q_data[AW-1:0];

    lef_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_cmd   (pop_cmd),
        .i_col   (pop_col),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
